[sv/incubator_climate_controller_assert.svh]
// Assertion macros shared by the controller modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef INCUBATOR_CLIMATE_CONTROLLER_ASSERT_SVH
`define INCUBATOR_CLIMATE_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ICC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ICC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/icc_pkg.sv]
`default_nettype none

package icc_pkg;

    localparam int TS_BITS          = 32;
    localparam int NOW_W            = 32;
    localparam int TEMP_W           = 11;
    localparam int HUMID_W          = 10;
    localparam int HOUR_W           = 5;
    localparam int MINUTE_W         = 6;
    localparam int MOD_W            = 11;
    localparam int SEC_W            = 16;
    localparam int MS_PER_SECOND    = 1000;
    localparam int MS_W             = SEC_W + 10;
    localparam int CMP_W            = (TS_BITS > MS_W) ? TS_BITS : MS_W;
    localparam int MINUTES_PER_HOUR = 60;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 16;

    localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RESET  = 11'sd380;
    localparam logic signed [TEMP_W-1:0] TEMP_LOW_RESET   = 11'sd370;
    localparam logic [HUMID_W-1:0]       HUMID_HIGH_RESET = 10'd600;
    localparam logic [HUMID_W-1:0]       HUMID_LOW_RESET  = 10'd500;
    localparam logic [MOD_W-1:0]         LAMP_START_RESET = 11'd360;
    localparam logic [MOD_W-1:0]         LAMP_STOP_RESET  = 11'd1080;
    localparam logic [SEC_W-1:0]         MOTOR_REST_RESET = 16'd3600;
    localparam logic [SEC_W-1:0]         MOTOR_RUN_RESET  = 16'd10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TEMP_HIGH  = 3'd0,
        REG_TEMP_LOW   = 3'd1,
        REG_HUMID_HIGH = 3'd2,
        REG_HUMID_LOW  = 3'd3,
        REG_LAMP_START = 3'd4,
        REG_LAMP_STOP  = 3'd5,
        REG_MOTOR_REST = 3'd6,
        REG_MOTOR_RUN  = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_high_limit;
        logic signed [TEMP_W-1:0] temp_low_limit;
        logic [HUMID_W-1:0]       humid_high_limit;
        logic [HUMID_W-1:0]       humid_low_limit;
        logic [MOD_W-1:0]         lamp_start_minute;
        logic [MOD_W-1:0]         lamp_stop_minute;
        logic [SEC_W-1:0]         motor_rest_seconds;
        logic [SEC_W-1:0]         motor_run_seconds;
    } cfg_t;

    typedef struct packed {
        logic [NOW_W-1:0]         now_ms;
        logic                     running;
        logic                     sample_ok;
        logic signed [TEMP_W-1:0] temperature;
        logic [HUMID_W-1:0]       humidity;
        logic [HOUR_W-1:0]        hour_of_day;
        logic [MINUTE_W-1:0]      minute_of_hour;
    } sample_t;

    typedef struct packed {
        logic heater_on;
        logic humidifier_on;
        logic lamp_on;
        logic motor_on;
    } result_t;

    // A window whose start is not below its stop wraps past midnight.
    function automatic logic in_window(
        input logic [MOD_W-1:0] now_min,
        input logic [MOD_W-1:0] on_min,
        input logic [MOD_W-1:0] off_min
    );
        logic hit;
        if (on_min < off_min)
        begin
            hit = (now_min >= on_min) && (now_min < off_min);
        end
        else
        begin
            hit = (now_min >= on_min) || (now_min < off_min);
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

[sv/icc_channels.sv]
`default_nettype none

interface icc_sample_if;
    logic                             valid;
    logic                             ready;
    logic [icc_pkg::NOW_W-1:0]        now_ms;
    logic                             running;
    logic                             sample_ok;
    logic signed [icc_pkg::TEMP_W-1:0] temperature;
    logic [icc_pkg::HUMID_W-1:0]      humidity;
    logic [icc_pkg::HOUR_W-1:0]       hour_of_day;
    logic [icc_pkg::MINUTE_W-1:0]     minute_of_hour;

    modport source (
        output valid, now_ms, running, sample_ok, temperature, humidity,
               hour_of_day, minute_of_hour,
        input  ready
    );
    modport sink (
        input  valid, now_ms, running, sample_ok, temperature, humidity,
               hour_of_day, minute_of_hour,
        output ready
    );
endinterface

interface icc_drive_if;
    logic valid;
    logic ready;
    logic heater_on;
    logic humidifier_on;
    logic lamp_on;
    logic motor_on;

    modport source (
        output valid, heater_on, humidifier_on, lamp_on, motor_on,
        input  ready
    );
    modport sink (
        input  valid, heater_on, humidifier_on, lamp_on, motor_on,
        output ready
    );
endinterface

`default_nettype wire

[sv/icc_cfg_regs.sv]
`default_nettype none

module icc_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [icc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [icc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output icc_pkg::cfg_t                           cfg
);

    icc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_high_limit    <= icc_pkg::TEMP_HIGH_RESET;
            cfg_reg.temp_low_limit     <= icc_pkg::TEMP_LOW_RESET;
            cfg_reg.humid_high_limit   <= icc_pkg::HUMID_HIGH_RESET;
            cfg_reg.humid_low_limit    <= icc_pkg::HUMID_LOW_RESET;
            cfg_reg.lamp_start_minute  <= icc_pkg::LAMP_START_RESET;
            cfg_reg.lamp_stop_minute   <= icc_pkg::LAMP_STOP_RESET;
            cfg_reg.motor_rest_seconds <= icc_pkg::MOTOR_REST_RESET;
            cfg_reg.motor_run_seconds  <= icc_pkg::MOTOR_RUN_RESET;
        end
        else if (cfg_we)
        begin
            case (icc_pkg::cfg_index_t'(cfg_index))
                icc_pkg::REG_TEMP_HIGH:
                    cfg_reg.temp_high_limit <= $signed(cfg_data[icc_pkg::TEMP_W-1:0]);
                icc_pkg::REG_TEMP_LOW:
                    cfg_reg.temp_low_limit <= $signed(cfg_data[icc_pkg::TEMP_W-1:0]);
                icc_pkg::REG_HUMID_HIGH:
                    cfg_reg.humid_high_limit <= cfg_data[icc_pkg::HUMID_W-1:0];
                icc_pkg::REG_HUMID_LOW:
                    cfg_reg.humid_low_limit <= cfg_data[icc_pkg::HUMID_W-1:0];
                icc_pkg::REG_LAMP_START:
                    cfg_reg.lamp_start_minute <= cfg_data[icc_pkg::MOD_W-1:0];
                icc_pkg::REG_LAMP_STOP:
                    cfg_reg.lamp_stop_minute <= cfg_data[icc_pkg::MOD_W-1:0];
                icc_pkg::REG_MOTOR_REST:
                    cfg_reg.motor_rest_seconds <= cfg_data[icc_pkg::SEC_W-1:0];
                icc_pkg::REG_MOTOR_RUN:
                    cfg_reg.motor_run_seconds <= cfg_data[icc_pkg::SEC_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[sv/icc_core.sv]
`default_nettype none

`include "incubator_climate_controller_assert.svh"

module icc_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire icc_pkg::cfg_t     cfg,
    input  wire icc_pkg::sample_t  sample,
    input  wire logic              update,
    output icc_pkg::result_t       state_next
);

    icc_pkg::result_t              state_reg;
    logic [icc_pkg::TS_BITS-1:0]   rest_start_ms_reg;
    logic [icc_pkg::TS_BITS-1:0]   rest_start_ms_next;
    logic [icc_pkg::TS_BITS-1:0]   run_start_ms_reg;
    logic [icc_pkg::TS_BITS-1:0]   run_start_ms_next;

    logic [icc_pkg::TS_BITS-1:0]   now_ts;
    logic [icc_pkg::TS_BITS-1:0]   rest_elapsed;
    logic [icc_pkg::TS_BITS-1:0]   run_elapsed;
    logic [icc_pkg::MS_W-1:0]      rest_ms;
    logic [icc_pkg::MS_W-1:0]      run_ms;
    logic [icc_pkg::MOD_W-1:0]     minute_of_day;
    logic                          rest_done;
    logic                          run_done;
    logic                          motor_mid;

    assign now_ts  = icc_pkg::TS_BITS'(sample.now_ms);
    assign rest_ms = icc_pkg::MS_W'(cfg.motor_rest_seconds)
                   * icc_pkg::MS_W'(icc_pkg::MS_PER_SECOND);
    assign run_ms  = icc_pkg::MS_W'(cfg.motor_run_seconds)
                   * icc_pkg::MS_W'(icc_pkg::MS_PER_SECOND);

    assign minute_of_day = icc_pkg::MOD_W'(sample.hour_of_day)
                         * icc_pkg::MOD_W'(icc_pkg::MINUTES_PER_HOUR)
                         + icc_pkg::MOD_W'(sample.minute_of_hour);

    assign rest_elapsed = now_ts - rest_start_ms_reg;

    // The rest period is checked first, so a run that starts in this item
    // measures its elapsed time from the new start.
    always_comb
    begin
        rest_done = !state_reg.motor_on &&
            (icc_pkg::CMP_W'(rest_elapsed) >= icc_pkg::CMP_W'(rest_ms));
        motor_mid         = state_reg.motor_on || rest_done;
        run_start_ms_next = rest_done ? now_ts : run_start_ms_reg;
        run_elapsed       = now_ts - run_start_ms_next;
        run_done          = motor_mid &&
            (icc_pkg::CMP_W'(run_elapsed) >= icc_pkg::CMP_W'(run_ms));
        rest_start_ms_next = run_done ? now_ts : rest_start_ms_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        if (sample.running)
        begin
            if (sample.sample_ok)
            begin
                if (sample.temperature > cfg.temp_high_limit)
                begin
                    state_next.heater_on = 1'b0;
                end
                else if (sample.temperature < cfg.temp_low_limit)
                begin
                    state_next.heater_on = 1'b1;
                end
                if (sample.humidity > cfg.humid_high_limit)
                begin
                    state_next.humidifier_on = 1'b0;
                end
                else if (sample.humidity < cfg.humid_low_limit)
                begin
                    state_next.humidifier_on = 1'b1;
                end
            end
            state_next.lamp_on = icc_pkg::in_window(minute_of_day,
                cfg.lamp_start_minute, cfg.lamp_stop_minute);
            state_next.motor_on = motor_mid && !run_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= '0;
            rest_start_ms_reg <= '0;
            run_start_ms_reg  <= '0;
        end
        else if (update)
        begin
            state_reg <= state_next;
            if (sample.running)
            begin
                rest_start_ms_reg <= rest_start_ms_next;
                run_start_ms_reg  <= run_start_ms_next;
            end
        end
    end

    `ICC_ASSERT_NEXT(a_idle_holds_state, update && !sample.running,
        $stable(state_reg), "drive states changed while not running")
    `ICC_ASSERT_NEXT(a_run_start_stamp,
        update && !state_reg.motor_on && state_next.motor_on,
        run_start_ms_reg == $past(now_ts), "motor run start not stamped")
    `ICC_ASSERT_SAME(a_heater_over_limit,
        sample.running && sample.sample_ok && (sample.temperature > cfg.temp_high_limit),
        !state_next.heater_on, "heater on above high limit")

endmodule

`default_nettype wire

[sv/incubator_climate_controller.sv]
// Incubator climate controller.
// Sample items arrive on the sample channel and each one produces exactly one
// item on the drive channel with the heater, humidifier, lamp and motor drives.
// Both channels use valid and ready; an item moves at a clock edge where both
// are high. The user must write the eight limit registers (cfg_we, cfg_index,
// cfg_data) only while no item is in flight; the block does not enforce it.
// An accepted item is held in an input register, where the hysteresis, lamp
// window and motor timer logic updates the held drive state, and its result
// is then loaded into the output register. While the drive channel does not
// stall, one item per cycle is taken; the state update between the two
// registers is combinational.
// When the drive channel stalls, the result waits in the output register, the
// input register still takes one more item, and the sample channel drops
// ready only when both registers are full.
// Reset clears the valid flags of both registers and all drive states and
// timer stamps, and loads the limit registers with their default values.
`default_nettype none

`include "incubator_climate_controller_assert.svh"

module incubator_climate_controller (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    icc_sample_if.sink                           sample,
    icc_drive_if.source                          drive,
    input  wire logic                            cfg_we,
    input  wire logic [icc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [icc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    icc_pkg::cfg_t    cfg;
    icc_pkg::sample_t sample_reg;
    logic             sample_valid_reg;
    icc_pkg::result_t result_reg;
    icc_pkg::result_t result_next;
    logic             result_valid_reg;
    logic             advance;

    icc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    icc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .sample     (sample_reg),
        .update     (advance),
        .state_next (result_next)
    );

    assign advance      = sample_valid_reg && (!result_valid_reg || drive.ready);
    assign sample.ready = !sample_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                sample_valid_reg <= sample.valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (drive.ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.ready && sample.valid)
        begin
            sample_reg.now_ms         <= sample.now_ms;
            sample_reg.running        <= sample.running;
            sample_reg.sample_ok      <= sample.sample_ok;
            sample_reg.temperature    <= sample.temperature;
            sample_reg.humidity       <= sample.humidity;
            sample_reg.hour_of_day    <= sample.hour_of_day;
            sample_reg.minute_of_hour <= sample.minute_of_hour;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign drive.valid         = result_valid_reg;
    assign drive.heater_on     = result_reg.heater_on;
    assign drive.humidifier_on = result_reg.humidifier_on;
    assign drive.lamp_on       = result_reg.lamp_on;
    assign drive.motor_on      = result_reg.motor_on;

    `ICC_ASSERT_NEXT(a_input_item_held, sample_valid_reg && !advance,
        sample_valid_reg, "held input item was lost")
    `ICC_ASSERT_NEXT(a_result_loaded, advance, result_valid_reg,
        "processed item produced no result")
    `ICC_ASSERT_SAME(a_no_overwrite, sample_valid_reg && result_valid_reg && !drive.ready,
        !advance, "pending result would be overwritten")

endmodule

`default_nettype wire
